// ----- hw/rtl/assert_macros.svh -----
// Assertion macros, used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check on every rising clock edge outside reset.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/pn3d_pkg.sv -----
// Shared constants and helpers of the 3D noise block.
package pn3d_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CELL_W        = 8;
  localparam int OUT_W         = 18;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;
  localparam int CMD_DEPTH     = 4;
  localparam int OUT_DEPTH     = 16;
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_EVAL   = 1'b1;

  // Width of one queued command: load flag, three cells, three fractions.
  function automatic int item_width(input int frac);
    return 1 + 3 * CELL_W + 3 * frac;
  endfunction
endpackage

// ----- hw/rtl/pn3d_perm_ram.sv -----
// Permutation table copy: one write port, two registered read ports.
module pn3d_perm_ram import pn3d_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [CELL_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [CELL_W-1:0] raddr_a,
  input  logic [CELL_W-1:0] raddr_b,
  output logic [CELL_W-1:0] rdata_a,
  output logic [CELL_W-1:0] rdata_b
);
  logic [CELL_W-1:0] mem [2**CELL_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- hw/rtl/pn3d_fifo.sv -----
// Small first-in first-out queue with full and empty flags.
module pn3d_fifo import pn3d_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end
endmodule

// ----- hw/rtl/pn3d_front.sv -----
// Front end: classify a beat and split coordinates into cell and fraction.
module pn3d_front import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               in_func,
  input  logic signed [31:0]                 in_coord_x,
  input  logic signed [31:0]                 in_coord_y,
  input  logic signed [31:0]                 in_coord_z,
  input  logic [CELL_W-1:0]                  in_perm_index,
  input  logic [CELL_W-1:0]                  in_perm_value,
  output logic [item_width(FRAC_BITS)-1:0]   item
);
  localparam int F = FRAC_BITS;

  logic              is_load;
  logic [CELL_W-1:0] cx, cy, cz;

  // A load reuses the x and y cell slots for table index and value.
  always_comb begin
    is_load = (in_func == FUNC_LOAD);
    cx = is_load ? in_perm_index : in_coord_x[F+CELL_W-1:F];
    cy = is_load ? in_perm_value : in_coord_y[F+CELL_W-1:F];
    cz = in_coord_z[F+CELL_W-1:F];
  end

  assign item = {is_load, cx, cy, cz,
                 in_coord_x[F-1:0], in_coord_y[F-1:0], in_coord_z[F-1:0]};
endmodule

// ----- hw/rtl/pn3d_back.sv -----
// Back end: hash, fade, gradient and trilinear blend pipeline.
module pn3d_back import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  logic [item_width(FRAC_BITS)-1:0]   q_data,
  output logic                               q_pop,
  input  logic                               res_pop,
  output logic                               res_valid,
  output logic signed [OUT_W-1:0]            res_value
);
  localparam int F  = FRAC_BITS;
  localparam int IW = item_width(FRAC_BITS);
  localparam int GW = F + 3;
  localparam int DW = F + 4;
  localparam int UW = F + 1;
  localparam int PW = 2 * F + 6;
  localparam int QW = F + 4;
  localparam int QX = F + 6;
  localparam int SW = (GW > OUT_W) ? GW : OUT_W;
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

  function automatic logic signed [GW-1:0] corner_dot(
    input logic [CELL_W-1:0] hv,
    input logic signed [GW-1:0] x,
    input logic signed [GW-1:0] y,
    input logic signed [GW-1:0] z
  );
    logic [3:0] h;
    logic signed [GW-1:0] u, v;
    h = hv[3:0];
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [PW-1:0] blend_mul(
    input logic [UW-1:0] f,
    input logic signed [GW-1:0] a,
    input logic signed [GW-1:0] b
  );
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return PW'($signed({1'b0, f})) * PW'(d);
  endfunction

  function automatic logic signed [GW-1:0] blend_add(
    input logic signed [GW-1:0] a,
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] s;
    s = p >>> F;
    return a + GW'(s);
  endfunction

  // issue
  logic              hd_load, issue_eval, issue_load;
  logic [CELL_W-1:0] hd_cx, hd_cy, hd_cz;
  logic [F-1:0]      hd_t [3];
  logic [CW-1:0]     cnt_r, cnt_nxt;

  // table copies
  logic              we   [7];
  logic [CELL_W-1:0] wad  [7];
  logic [CELL_W-1:0] wdat [7];
  logic [CELL_W-1:0] ra   [7];
  logic [CELL_W-1:0] rb   [7];
  logic [CELL_W-1:0] da   [7];
  logic [CELL_W-1:0] db   [7];

  // stage registers
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;
  logic s1_ld_r, s2_ld_r;
  logic [CELL_W-1:0] s1_cx_r, s1_cy_r, s1_cz_r, s2_cx_r, s2_cy_r, s2_cz_r;
  logic [F-1:0]      s1_t_r [3];
  logic [2*F-1:0]    s1_tt_r [3];
  logic [F-1:0]      s2_t_r [3];
  logic [F-1:0]      s2_r_r [3];
  logic [QW-1:0]     s2_q_r [3];
  logic [F-1:0]      s3_t_r [3];
  logic [UW-1:0]     s3_f_r [3];
  logic signed [GW-1:0] s4_g_r [8];
  logic [UW-1:0]     s4_f_r [3];
  logic signed [PW-1:0] s5_p_r [4];
  logic signed [GW-1:0] s5_a_r [4];
  logic [UW-1:0]     s5_f_r [2];
  logic signed [GW-1:0] s6_n_r [4];
  logic [UW-1:0]     s6_f_r [2];
  logic signed [PW-1:0] s7_p_r [2];
  logic signed [GW-1:0] s7_a_r [2];
  logic [UW-1:0]     s7_w_r;
  logic signed [GW-1:0] s8_m_r [2];
  logic [UW-1:0]     s8_w_r;
  logic signed [PW-1:0] s9_p_r;
  logic signed [GW-1:0] s9_a_r;

  // stage logic
  logic [CELL_W-1:0] ha, hb, haa, hab, hba, hbb;
  logic [F-1:0]      r_nxt [3];
  logic [QW-1:0]     q_nxt [3];
  logic [UW-1:0]     f_nxt [3];
  logic signed [GW-1:0] o0 [3];
  logic signed [GW-1:0] o1 [3];
  logic signed [GW-1:0] g_nxt [8];
  logic signed [GW-1:0] rsum;
  logic signed [SW-1:0] rx;

  assign hd_load = q_data[IW-1];
  assign hd_cx   = q_data[IW-2 -: CELL_W];
  assign hd_cy   = q_data[IW-2-CELL_W -: CELL_W];
  assign hd_cz   = q_data[IW-2-2*CELL_W -: CELL_W];
  assign hd_t[0] = q_data[3*F-1 -: F];
  assign hd_t[1] = q_data[2*F-1 -: F];
  assign hd_t[2] = q_data[F-1:0];

  // Evaluations need a reserved slot in the result queue; loads do not.
  assign issue_eval = !q_empty && !hd_load && (cnt_r < CW'(OUT_DEPTH));
  assign issue_load = !q_empty && hd_load;
  assign q_pop      = issue_eval || issue_load;

  always_comb begin
    cnt_nxt = cnt_r;
    if (issue_eval && !res_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (res_pop && !issue_eval) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Each copy is written as the load passes the stage that reads it.
  always_comb begin
    we[0] = issue_load;
    wad[0] = hd_cx;
    wdat[0] = hd_cy;
    ra[0] = hd_cx;
    rb[0] = hd_cx + CELL_W'(1);
    ha = da[0] + s1_cy_r;
    hb = db[0] + s1_cy_r;
    for (int k = 1; k < 3; k++) begin
      we[k] = s1_v_r && s1_ld_r;
      wad[k] = s1_cx_r;
      wdat[k] = s1_cy_r;
    end
    ra[1] = ha;
    rb[1] = ha + CELL_W'(1);
    ra[2] = hb;
    rb[2] = hb + CELL_W'(1);
    haa = da[1] + s2_cz_r;
    hab = db[1] + s2_cz_r;
    hba = da[2] + s2_cz_r;
    hbb = db[2] + s2_cz_r;
    for (int k = 3; k < 7; k++) begin
      we[k] = s2_v_r && s2_ld_r;
      wad[k] = s2_cx_r;
      wdat[k] = s2_cy_r;
    end
    ra[3] = haa;
    rb[3] = haa + CELL_W'(1);
    ra[4] = hab;
    rb[4] = hab + CELL_W'(1);
    ra[5] = hba;
    rb[5] = hba + CELL_W'(1);
    ra[6] = hbb;
    rb[6] = hbb + CELL_W'(1);
  end

  for (genvar k = 0; k < 7; k++) begin : g_ram
    pn3d_perm_ram u_ram (
      .clk     (clk),
      .we      (we[k]),
      .waddr   (wad[k]),
      .wdata   (wdat[k]),
      .raddr_a (ra[k]),
      .raddr_b (rb[k]),
      .rdata_a (da[k]),
      .rdata_b (db[k])
    );
  end

  // Fade polynomial, split over three multiplies.
  always_comb begin
    logic [2*F-1:0] rm;
    logic [2*F+2:0] six_tt;
    logic [QX-1:0]  qf;
    logic [2*F+3:0] fm;
    for (int i = 0; i < 3; i++) begin
      rm = (2*F)'(s1_tt_r[i][2*F-1:F]) * (2*F)'(s1_t_r[i]);
      r_nxt[i] = rm[2*F-1:F];
      six_tt = {1'b0, s1_tt_r[i], 2'b00} + {2'b00, s1_tt_r[i], 1'b0};
      qf = QX'(six_tt >> F) + (QX'(10) << F) - QX'(s1_t_r[i]) * QX'(15);
      q_nxt[i] = qf[QW-1:0];
      fm = (2*F+4)'(s2_r_r[i]) * (2*F+4)'(s2_q_r[i]);
      f_nxt[i] = fm[2*F:F];
    end
  end

  // Corner gradients.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o0[i] = GW'(s3_t_r[i]);
      o1[i] = GW'(s3_t_r[i]) - (GW'(1) << F);
    end
    g_nxt[0] = corner_dot(da[3], o0[0], o0[1], o0[2]);
    g_nxt[1] = corner_dot(da[5], o1[0], o0[1], o0[2]);
    g_nxt[2] = corner_dot(da[4], o0[0], o1[1], o0[2]);
    g_nxt[3] = corner_dot(da[6], o1[0], o1[1], o0[2]);
    g_nxt[4] = corner_dot(db[3], o0[0], o0[1], o1[2]);
    g_nxt[5] = corner_dot(db[5], o1[0], o0[1], o1[2]);
    g_nxt[6] = corner_dot(db[4], o0[0], o1[1], o1[2]);
    g_nxt[7] = corner_dot(db[6], o1[0], o1[1], o1[2]);
  end

  // Final blend and saturation.
  always_comb begin
    rsum = blend_add(s9_a_r, s9_p_r);
    rx = SW'(rsum);
    if (rx > SAT_HI) begin
      rx = SAT_HI;
    end else if (rx < SAT_LO) begin
      rx = SAT_LO;
    end
  end

  assign res_valid = s9_v_r;
  assign res_value = rx[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && !s2_ld_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ld_r <= hd_load;
    s1_cx_r <= hd_cx;
    s1_cy_r <= hd_cy;
    s1_cz_r <= hd_cz;
    s2_ld_r <= s1_ld_r;
    s2_cx_r <= s1_cx_r;
    s2_cy_r <= s1_cy_r;
    s2_cz_r <= s1_cz_r;
    for (int i = 0; i < 3; i++) begin
      s1_t_r[i]  <= hd_t[i];
      s1_tt_r[i] <= (2*F)'(hd_t[i]) * (2*F)'(hd_t[i]);
      s2_t_r[i]  <= s1_t_r[i];
      s2_r_r[i]  <= r_nxt[i];
      s2_q_r[i]  <= q_nxt[i];
      s3_t_r[i]  <= s2_t_r[i];
      s3_f_r[i]  <= f_nxt[i];
      s4_f_r[i]  <= s3_f_r[i];
    end
    for (int j = 0; j < 8; j++) begin
      s4_g_r[j] <= g_nxt[j];
    end
    for (int j = 0; j < 4; j++) begin
      s5_p_r[j] <= blend_mul(s4_f_r[0], s4_g_r[2*j], s4_g_r[2*j+1]);
      s5_a_r[j] <= s4_g_r[2*j];
      s6_n_r[j] <= blend_add(s5_a_r[j], s5_p_r[j]);
    end
    s5_f_r[0] <= s4_f_r[1];
    s5_f_r[1] <= s4_f_r[2];
    s6_f_r[0] <= s5_f_r[0];
    s6_f_r[1] <= s5_f_r[1];
    s7_p_r[0] <= blend_mul(s6_f_r[0], s6_n_r[0], s6_n_r[1]);
    s7_p_r[1] <= blend_mul(s6_f_r[0], s6_n_r[2], s6_n_r[3]);
    s7_a_r[0] <= s6_n_r[0];
    s7_a_r[1] <= s6_n_r[2];
    s7_w_r    <= s6_f_r[1];
    s8_m_r[0] <= blend_add(s7_a_r[0], s7_p_r[0]);
    s8_m_r[1] <= blend_add(s7_a_r[1], s7_p_r[1]);
    s8_w_r    <= s7_w_r;
    s9_p_r    <= blend_mul(s8_w_r, s8_m_r[0], s8_m_r[1]);
    s9_a_r    <= s8_m_r[0];
  end
endmodule

// ----- hw/rtl/perlin_noise_3d.sv -----
// Top level of the 3D improved gradient noise unit.
// Throughput: one beat per clock, loads and evaluations alike, steady state,
//   while no evaluation waits for result-queue credits.
// Results pass the command queue, the 9-stage hash, fade and blend pipeline and the result queue.
// A load writes table copy 0 at issue, copies 1-2 from stage 1, 3-6 from stage 2, in beat order.
// Reset empties both queues and the pipeline; the table keeps its contents.
`include "assert_macros.svh"
module perlin_noise_3d import pn3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_func,
  input  logic signed [31:0]       in_coord_x,
  input  logic signed [31:0]       in_coord_y,
  input  logic signed [31:0]       in_coord_z,
  input  logic [CELL_W-1:0]        in_perm_index,
  input  logic [CELL_W-1:0]        in_perm_value,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [OUT_W-1:0]  out_noise_value
);
  localparam int IW = item_width(FRAC_BITS);

  logic [IW-1:0]           item, q_data;
  logic                    q_empty, q_pop;
  logic                    res_valid, res_pop, ofifo_full;
  logic signed [OUT_W-1:0] res_value;
  logic [OUT_W-1:0]        out_raw;

  // Classify the beat and split its coordinates.
  pn3d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .in_func       (in_func),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_perm_index (in_perm_index),
    .in_perm_value (in_perm_value),
    .item          (item)
  );

  // Command queue: decouples the port from pipeline issue.
  pn3d_fifo #(.W(IW), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (item),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  // Pipeline; it never stalls, issue is held back by result-queue credits.
  pn3d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_pop   (res_pop),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  assign res_pop = out_pop && !out_empty;

  // Result queue: holds finished values while the consumer stalls.
  pn3d_fifo #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res_value),
    .full  (ofifo_full),
    .pop   (out_pop),
    .dout  (out_raw),
    .empty (out_empty)
  );

  assign out_noise_value = $signed(out_raw);

  // Credits must keep a slot free for every finished value.
  `ASSERT_ON_CLK(a_res_room, res_valid |-> !ofifo_full, "result queue overflow")
  // Issue only from a filled command queue.
  `ASSERT_ON_CLK(a_issue_src, q_pop |-> !q_empty, "issue from empty command queue")
  // The result queue comes out of reset empty and the command queue not full.
  `ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (out_empty && !in_full), "queues not cleared")
endmodule
